>>> rtl/pfb_pkg.sv
`timescale 1ns / 1ps
// Package for the page framebuffer draw engine: panel and memory sizes,
// item and memory request types, state codes and the pixel address function.
// No dependencies.
package pfb_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int MEM_DEPTH    = 1024;
  localparam int MEM_AW       = $clog2(MEM_DEPTH);
  localparam int COORD_W      = 10;
  localparam int SPAN_W       = 8;
  localparam int CFG_DW       = 10;
  localparam int CFG_IW       = 2;
  localparam int SUM_W        = 17;

  typedef enum logic [1:0] {
    MODE_FILL    = 2'd0,
    MODE_LINE    = 2'd1,
    MODE_OUTLINE = 2'd2,
    MODE_READ    = 2'd3
  } mode_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_PEN_COLOR     = 2'd0,
    CFG_FILL_COLOR    = 2'd1,
    CFG_RENDER_OFFSET = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX,
    ST_WRITE,
    ST_RDATA,
    ST_NEXT,
    ST_LSETUP,
    ST_LNORM,
    ST_LPT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] first_x;
    logic [7:0] first_y;
    logic [7:0] second_x;
    logic [7:0] second_y;
  } pfb_in_t;

  typedef struct packed {
    logic pixel_value;
    logic clipped;
  } pfb_out_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic              ok;
    logic [MEM_AW-1:0] addr;
  } pix_t;

  function automatic pix_t pix_addr(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y,
                                    input logic [MEM_AW-1:0] offset);
    pix_t             res;
    logic [SUM_W-1:0] sum;
    logic             on_panel;
    sum = SUM_W'(offset) + SUM_W'(y[COORD_W-1:3]) * SUM_W'(PANEL_WIDTH)
          + SUM_W'(x);
    on_panel = !x[COORD_W-1] && !y[COORD_W-1] &&
               (int'(x) < PANEL_WIDTH) && (int'(y) < PANEL_HEIGHT);
    res.ok   = on_panel && (sum < SUM_W'(MEM_DEPTH));
    res.addr = sum[MEM_AW-1:0];
    return res;
  endfunction

endpackage

>>> rtl/page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// Page framebuffer draw engine, top level: command sequencer, line stepper
// and pixel read-modify-write. Depends on pfb_pkg and pfb_frame_mem.
//
// Usage: one input item is one command (fill rectangle, line, rectangle
// outline, read pixel); it yields exactly one output item with the read
// pixel and a clip flag. Both channels use valid/stall; an item moves on a
// clock edge with valid high and stall low. Configuration registers (pen
// color, fill color, render offset) are written through cfg_we_i,
// cfg_index_i and cfg_wdata_i; the user must write them only while no
// command is in flight, the block itself does not enforce this.
// After reset the frame memory is cleared, one byte per cycle, over all
// 1024 bytes; in_stall_o stays high meanwhile, configuration writes still
// work. Each drawn pixel is a byte read-modify-write through the single
// memory port (pixel state reads, write state writes; skipped if clipped);
// a line pixel first steps, normalizes the remainder and sets the point.
// A pixel read goes from the pixel to the read-data state (skipped when
// clipped), an empty fill skips to done, which loads the output register.
// Commands run one at a time. A finished item sits in the output register
// while the next command is accepted; if the receiver stalls, the engine
// holds its next result until the register frees up.
module page_framebuffer_draw_engine import pfb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfb_in_t           in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfb_out_t          out_item_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  state_e state_q, state_d;

  logic              pen_q, fill_q;
  logic [MEM_AW-1:0] offset_q;

  mode_e                      mode_q;
  logic signed [COORD_W-1:0]  cx0_q, cy0_q, cx1_q, cy1_q;
  logic [SPAN_W-1:0]          fill_w_q, rem_x_q, rem_y_q;
  edge_e                      edge_q;

  logic                       swap_q, maj_neg_q, min_neg_q;
  logic signed [COORD_W-1:0]  maj_cur_q, maj_end_q, min_base_q;
  logic [SPAN_W-1:0]          num_q, den_q, quo_q;
  logic [SPAN_W:0]            rem_q;

  logic signed [COORD_W-1:0]  px_q, py_q;
  logic [MEM_AW-1:0]          addr_q;
  logic [2:0]                 bit_q;
  logic                       pv_q, clip_q;

  logic                       out_valid_q;
  pfb_out_t                   out_q;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic       mem_busy;

  logic       in_acc, out_free, out_load;
  pix_t       pix;
  logic       line_end, last_line, fill_last, fill_empty;
  logic [7:0] mask;

  logic signed [COORD_W-1:0] lx0, ly0, lx1, ly1;
  logic signed [COORD_W:0]   run, rise;
  logic [SPAN_W-1:0]         abs_run, abs_rise;

  pfb_frame_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(mem_rdata),
    .busy_o (mem_busy)
  );

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pix        = pix_addr(px_q, py_q, offset_q);
  assign line_end   = (maj_cur_q == maj_end_q);
  assign last_line  = (mode_q == MODE_LINE) || (edge_q == EDGE_LEFT);
  assign fill_last  = (rem_x_q == '0) && (rem_y_q == '0);
  assign fill_empty = (in_item_i.second_x == '0) || (in_item_i.second_y == '0);
  assign mask       = 8'h01 << bit_q;

  always_comb begin
    lx0 = cx0_q;
    ly0 = cy0_q;
    lx1 = cx1_q;
    ly1 = cy1_q;
    if (mode_q == MODE_OUTLINE) begin
      unique case (edge_q)
        EDGE_TOP: begin
          lx0 = cx0_q; ly0 = cy0_q; lx1 = cx1_q; ly1 = cy0_q;
        end
        EDGE_RIGHT: begin
          lx0 = cx1_q; ly0 = cy0_q; lx1 = cx1_q; ly1 = cy1_q;
        end
        EDGE_BOTTOM: begin
          lx0 = cx0_q; ly0 = cy1_q; lx1 = cx1_q; ly1 = cy1_q;
        end
        EDGE_LEFT: begin
          lx0 = cx0_q; ly0 = cy0_q; lx1 = cx0_q; ly1 = cy1_q;
        end
        default: begin
          lx0 = cx0_q; ly0 = cy0_q; lx1 = cx1_q; ly1 = cy1_q;
        end
      endcase
    end
    run      = {lx1[COORD_W-1], lx1} - {lx0[COORD_W-1], lx0};
    rise     = {ly1[COORD_W-1], ly1} - {ly0[COORD_W-1], ly0};
    abs_run  = run[COORD_W] ? SPAN_W'(-run) : SPAN_W'(run);
    abs_rise = rise[COORD_W] ? SPAN_W'(-rise) : SPAN_W'(rise);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (mode_e'(in_item_i.mode))
            MODE_FILL:    state_d = fill_empty ? ST_DONE : ST_PIX;
            MODE_LINE:    state_d = ST_LSETUP;
            MODE_OUTLINE: state_d = ST_LSETUP;
            MODE_READ:    state_d = ST_PIX;
            default:      state_d = ST_PIX;
          endcase
        end
      end
      ST_PIX: begin
        if (!pix.ok) begin
          state_d = (mode_q == MODE_READ) ? ST_DONE : ST_NEXT;
        end else begin
          state_d = (mode_q == MODE_READ) ? ST_RDATA : ST_WRITE;
        end
      end
      ST_WRITE: state_d = ST_NEXT;
      ST_RDATA: state_d = ST_DONE;
      ST_NEXT: begin
        if (mode_q == MODE_FILL) begin
          state_d = fill_last ? ST_DONE : ST_PIX;
        end else if (line_end) begin
          state_d = last_line ? ST_DONE : ST_LSETUP;
        end else begin
          state_d = ST_LNORM;
        end
      end
      ST_LSETUP: state_d = ST_LPT;
      ST_LNORM:  state_d = (rem_q >= {1'b0, den_q}) ? ST_LNORM : ST_LPT;
      ST_LPT:    state_d = ST_PIX;
      ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE) || mem_busy;
    out_load      = (state_q == ST_DONE) && out_free;
    mem_req       = '0;
    mem_req.addr  = addr_q;
    mem_req.wdata = mem_rdata & ~mask;
    unique case (state_q)
      ST_PIX: begin
        mem_req.rd   = pix.ok;
        mem_req.addr = pix.addr;
      end
      ST_WRITE: begin
        mem_req.wr = 1'b1;
        if ((mode_q == MODE_FILL) ? fill_q : pen_q) begin
          mem_req.wdata = mem_rdata | mask;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pen_q       <= 1'b1;
      fill_q      <= 1'b1;
      offset_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_PEN_COLOR:     pen_q    <= cfg_wdata_i[0];
          CFG_FILL_COLOR:    fill_q   <= cfg_wdata_i[0];
          CFG_RENDER_OFFSET: offset_q <= cfg_wdata_i[MEM_AW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pixel_value <= pv_q;
      out_q.clipped     <= clip_q;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mode_q   <= mode_e'(in_item_i.mode);
          cx0_q    <= COORD_W'(in_item_i.first_x);
          cy0_q    <= COORD_W'(in_item_i.first_y);
          if (mode_e'(in_item_i.mode) == MODE_OUTLINE) begin
            cx1_q <= COORD_W'(in_item_i.first_x) + COORD_W'(in_item_i.second_x) - 1'b1;
            cy1_q <= COORD_W'(in_item_i.first_y) + COORD_W'(in_item_i.second_y) - 1'b1;
          end else begin
            cx1_q <= COORD_W'(in_item_i.second_x);
            cy1_q <= COORD_W'(in_item_i.second_y);
          end
          fill_w_q <= in_item_i.second_x;
          rem_x_q  <= in_item_i.second_x - 1'b1;
          rem_y_q  <= in_item_i.second_y - 1'b1;
          edge_q   <= EDGE_TOP;
          px_q     <= COORD_W'(in_item_i.first_x);
          py_q     <= COORD_W'(in_item_i.first_y);
          pv_q     <= 1'b0;
          clip_q   <= 1'b0;
        end
      end
      ST_PIX: begin
        addr_q <= pix.addr;
        bit_q  <= py_q[2:0];
        if (!pix.ok) begin
          clip_q <= 1'b1;
        end
      end
      ST_RDATA: pv_q <= mem_rdata[bit_q];
      ST_NEXT: begin
        if (mode_q == MODE_FILL) begin
          if (rem_x_q == '0) begin
            rem_x_q <= fill_w_q - 1'b1;
            rem_y_q <= rem_y_q - 1'b1;
            px_q    <= cx0_q;
            py_q    <= py_q + 1'b1;
          end else begin
            rem_x_q <= rem_x_q - 1'b1;
            px_q    <= px_q + 1'b1;
          end
        end else if (line_end) begin
          edge_q <= edge_e'(edge_q + 2'd1);
        end else begin
          maj_cur_q <= maj_neg_q ? maj_cur_q - 1'b1 : maj_cur_q + 1'b1;
          rem_q     <= rem_q + {1'b0, num_q};
        end
      end
      ST_LSETUP: begin
        quo_q <= '0;
        rem_q <= '0;
        if (run != '0) begin
          swap_q     <= 1'b0;
          maj_cur_q  <= lx0;
          maj_end_q  <= lx1;
          maj_neg_q  <= run[COORD_W];
          min_base_q <= ly0;
          min_neg_q  <= rise[COORD_W];
          num_q      <= abs_rise;
          den_q      <= abs_run;
        end else begin
          swap_q     <= 1'b1;
          maj_cur_q  <= ly0;
          maj_end_q  <= ly1;
          maj_neg_q  <= rise[COORD_W];
          min_base_q <= lx0;
          min_neg_q  <= 1'b0;
          num_q      <= '0;
          den_q      <= SPAN_W'(1);
        end
      end
      ST_LNORM: begin
        if (rem_q >= {1'b0, den_q}) begin
          rem_q <= rem_q - {1'b0, den_q};
          quo_q <= quo_q + 1'b1;
        end
      end
      ST_LPT: begin
        if (swap_q) begin
          px_q <= min_base_q;
          py_q <= maj_cur_q;
        end else begin
          px_q <= maj_cur_q;
          py_q <= min_neg_q ? min_base_q - COORD_W'(quo_q)
                            : min_base_q + COORD_W'(quo_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted item did not start a command");

  a_write_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> $past(state_q) == ST_PIX && $past(mem_req.rd))
    else $error("byte write without a preceding read");

  a_line_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LPT |-> rem_q < {1'b0, den_q} && den_q != '0)
    else $error("line stepper remainder not normalized");

  a_no_access_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> !mem_req.rd && !mem_req.wr && in_stall_o)
    else $error("frame memory accessed during clearing pass");
`endif

endmodule

>>> rtl/pfb_frame_mem.sv
`timescale 1ns / 1ps
// Frame memory: one byte-wide synchronous RAM with registered read data and a
// clearing pass after reset. Depends on pfb_pkg.
module pfb_frame_mem import pfb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output logic [7:0] rdata_o,
  output logic     busy_o
);

  logic [7:0]        mem_q [MEM_DEPTH];
  logic [7:0]        rdata_q;
  logic              clr_q;
  logic [MEM_AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule
